FILE: hw/rtl/shabsh_pkg.sv
// shabsh_pkg: shared types, constants and functions of the SHA-256 byte-stream hasher.
// No dependencies; imported by shabsh_round, shabsh_sched and the top level.

package shabsh_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [0:7] hstate_t;  // index 0 is a / H0

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned DigestLen  = 8;
  localparam logic [7:0]  PadMarker  = 8'h80;
  localparam logic [5:0]  LenStart   = 6'd56;

  localparam hstate_t InitHash = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_FOLD,
    ST_PAD,
    ST_OUT
  } state_t;

  // schedule window control from the sequencer
  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_val;
    logic       shift_word;
  } sched_ctl_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    case (t)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

FILE: hw/rtl/shabsh_round.sv
// shabsh_round: one SHA-256 compression round, shared over all 64 rounds.
// Depends on shabsh_pkg.

module shabsh_round
  import shabsh_pkg::*;
(
  input  hstate_t v_in,
  input  word_t   k_in,
  input  word_t   w_in,
  output hstate_t v_out
);

  word_t ch, mj, t1, t2;

  always_comb begin
    ch = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
    mj = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
    t1 = v_in[7] + bsig1(v_in[4]) + ch + k_in + w_in;
    t2 = bsig0(v_in[0]) + mj;
    v_out[0] = t1 + t2;
    v_out[1] = v_in[0];
    v_out[2] = v_in[1];
    v_out[3] = v_in[2];
    v_out[4] = v_in[3] + t1;
    v_out[5] = v_in[4];
    v_out[6] = v_in[5];
    v_out[7] = v_in[6];
  end

endmodule

FILE: hw/rtl/shabsh_sched.sv
// shabsh_sched: 16-word message window; byte shift-in for loading and padding,
// word shift with schedule expansion during compression. Depends on shabsh_pkg.

module shabsh_sched
  import shabsh_pkg::*;
(
  input  logic       clk,
  input  sched_ctl_t ctl,
  output word_t      w_t
);

  word_t w_r   [16];
  word_t w_nxt [16];
  word_t w_new;

  // next schedule word W[t+16] from the current window
  assign w_new = ssig1(w_r[14]) + w_r[9] + ssig0(w_r[1]) + w_r[0];
  assign w_t   = w_r[0];

  always_comb begin
    for (int i = 0; i < 16; i++) w_nxt[i] = w_r[i];
    if (ctl.shift_word) begin
      for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
      w_nxt[15] = w_new;
    end else if (ctl.shift_byte) begin
      // whole window moves up one byte, oldest byte lands at top of word 0
      for (int i = 0; i < 15; i++) w_nxt[i] = {w_r[i][23:0], w_r[i+1][31:24]};
      w_nxt[15] = {w_r[15][23:0], ctl.byte_val};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) w_r[i] <= w_nxt[i];
  end

endmodule

FILE: hw/rtl/sha256_byte_stream_hasher_top.sv
// sha256_byte_stream_hasher_top: SHA-256 over a byte stream, digest as eight words.
// Depends on shabsh_pkg, shabsh_sched and shabsh_round.

// The block hashes a message delivered one byte per input transfer (in_tuser = byte
// present, in_tlast = end of message) and returns the 256-bit digest as eight output
// transfers, most significant word first, out_tlast on the eighth. One input transfer
// is taken each cycle while in_tready is high; after every 64th byte the block runs
// 64 rounds on its single shared round unit and then folds the result into the
// chaining value. On end of message the padding bytes go through the same byte-wide
// window one per cycle (64 - n bytes, n = bytes in the open block), then through
// compression; when n >= 56 that happens twice. The eight digest transfers follow at
// one per cycle as the sink accepts them. in_tready is low during compression, fold,
// padding and readout; after the last digest word the chaining value returns to the
// initial hash and the byte count to zero. The bit length wraps modulo 2^64.

module sha256_byte_stream_hasher_top
  import shabsh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,   // end_of_message
  // digest stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        out_tlast   // last_word
);

  state_t      state_r, state_nxt;
  logic [60:0] count_r, count_nxt;        // message bytes, wraps modulo 2^61
  logic [5:0]  rnd_r, rnd_nxt;            // round index during compression
  logic [5:0]  pad_pos_r, pad_pos_nxt;    // byte position within the padding block
  logic [2:0]  idx_r, idx_nxt;            // digest word being offered
  logic        first_r, first_nxt;        // 0x80 marker still to go
  logic        tail_r, tail_nxt;          // this padding block carries the length
  logic        end_pend_r, end_pend_nxt;  // message closed, padding owed
  logic        last_blk_r, last_blk_nxt;  // compression under way is the final one
  hstate_t     hash_r, hash_nxt;
  hstate_t     v_r, v_nxt;
  hstate_t     v_rnd;

  logic        in_xfer, out_xfer;
  logic [5:0]  pos;
  logic [63:0] len_bits;
  logic [7:0]  len_byte, pad_byte;
  word_t       w_t;
  sched_ctl_t  sctl;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;
  assign pos      = count_r[5:0];
  assign len_bits = {count_r, 3'b000};
  // length goes out most significant byte first at positions 56..63
  assign len_byte = len_bits[{~pad_pos_r[2:0], 3'b000} +: 8];
  assign pad_byte = first_r ? PadMarker :
                    (tail_r && pad_pos_r >= LenStart) ? len_byte : 8'h00;

  shabsh_sched u_sched (
    .clk (clk),
    .ctl (sctl),
    .w_t (w_t)
  );

  shabsh_round u_round (
    .v_in  (v_r),
    .k_in  (round_k(rnd_r)),
    .w_in  (w_t),
    .v_out (v_rnd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser && pos == 6'(BlockBytes - 1)) state_nxt = ST_COMP;
          else if (in_tlast)                        state_nxt = ST_PAD;
        end
      end
      ST_COMP: begin
        if (rnd_r == 6'(Rounds - 1)) state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        if (last_blk_r)      state_nxt = ST_OUT;
        else if (end_pend_r) state_nxt = ST_PAD;
        else                 state_nxt = ST_IDLE;
      end
      ST_PAD: begin
        if (pad_pos_r == 6'(BlockBytes - 1)) state_nxt = ST_COMP;
      end
      ST_OUT: begin
        if (out_tready && idx_r == 3'(DigestLen - 1)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // handshake and window control
  always_comb begin
    in_tready       = 1'b0;
    out_tvalid      = 1'b0;
    sctl.shift_byte = 1'b0;
    sctl.shift_word = 1'b0;
    sctl.byte_val   = in_tdata;
    case (state_r)
      ST_IDLE: begin
        in_tready       = 1'b1;
        sctl.shift_byte = in_xfer && in_tuser;
      end
      ST_COMP: sctl.shift_word = 1'b1;
      ST_PAD: begin
        sctl.shift_byte = 1'b1;
        sctl.byte_val   = pad_byte;
      end
      ST_OUT:  out_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign out_tdata = {5'b0, idx_r, hash_r[idx_r]};
  assign out_tlast = (idx_r == 3'(DigestLen - 1));

  // datapath and bookkeeping
  always_comb begin
    count_nxt    = count_r;
    rnd_nxt      = rnd_r;
    pad_pos_nxt  = pad_pos_r;
    idx_nxt      = idx_r;
    first_nxt    = first_r;
    tail_nxt     = tail_r;
    end_pend_nxt = end_pend_r;
    last_blk_nxt = last_blk_r;
    hash_nxt     = hash_r;
    v_nxt        = v_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser) count_nxt = count_r + 61'd1;
          if (in_tlast) begin
            end_pend_nxt = 1'b1;
            first_nxt    = 1'b1;
            pad_pos_nxt  = in_tuser ? pos + 6'd1 : pos;
            tail_nxt     = pad_pos_nxt < LenStart;
          end
          v_nxt = hash_r;
        end
      end
      ST_COMP: begin
        v_nxt   = v_rnd;
        rnd_nxt = rnd_r + 6'd1;
      end
      ST_FOLD: begin
        for (int i = 0; i < 8; i++) hash_nxt[i] = hash_r[i] + v_r[i];
        if (!last_blk_r && end_pend_r) begin
          pad_pos_nxt = 6'd0;
          tail_nxt    = 1'b1;
        end
      end
      ST_PAD: begin
        first_nxt   = 1'b0;
        pad_pos_nxt = pad_pos_r + 6'd1;
        if (pad_pos_r == 6'(BlockBytes - 1)) begin
          last_blk_nxt = tail_r;
          v_nxt        = hash_r;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'(DigestLen - 1)) begin
            hash_nxt     = InitHash;
            count_nxt    = '0;
            end_pend_nxt = 1'b0;
            last_blk_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      count_r    <= '0;
      rnd_r      <= '0;
      pad_pos_r  <= '0;
      idx_r      <= '0;
      first_r    <= 1'b0;
      tail_r     <= 1'b0;
      end_pend_r <= 1'b0;
      last_blk_r <= 1'b0;
      hash_r     <= InitHash;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      rnd_r      <= rnd_nxt;
      pad_pos_r  <= pad_pos_nxt;
      idx_r      <= idx_nxt;
      first_r    <= first_nxt;
      tail_r     <= tail_nxt;
      end_pend_r <= end_pend_nxt;
      last_blk_r <= last_blk_nxt;
      hash_r     <= hash_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

endmodule

FILE: hw/rtl/shabsh_chk.sv
// shabsh_chk: port-level checks on the hasher's streams, bound to the top level.
// Depends on sha256_byte_stream_hasher_top only through the bind.

module shabsh_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tuser,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  // input is never taken while a digest is being offered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready during digest readout");

  // last flag only on word seven
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[34:32] == 3'd7)))
    else $error("out_tlast does not match word index");

  // words come in order without gaps
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && out_tdata[34:32] == 3'($past(out_tdata[34:32]) + 3'd1)))
    else $error("digest word sequence broken");

  // digest ends after the last transfer
  a_end_ro: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (!out_tvalid && in_tready))
    else $error("readout did not end after last word");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled output changed");

endmodule

bind sha256_byte_stream_hasher_top shabsh_chk u_shabsh_chk (.*);

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for sha256_byte_stream_hasher_top.
// Holds its own SHA-256 predictor and needs only the RTL (shabsh_pkg and the hasher).

module tb_top;

  // ---------------------------------------------------------------------------
  // Constants
  // ---------------------------------------------------------------------------
  localparam int RAND_ITEMS   = 250;   // random-part input transfers, roughly
  localparam int CALM_ITEMS   = 30;    // no new idle bursts once fewer items than this remain
  localparam int STALL_LIMIT  = 4000;  // cycles with no transfer while work is pending
  localparam int DRAIN_CYCLES = 300;   // quiet time after the last digest word
  localparam int MAX_REPORTS  = 10;

  // round constants, word t at [(63-t)*32 +: 32]
  localparam logic [64*32-1:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // initial hash, H0 at the top
  localparam logic [8*32-1:0] START_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // ---------------------------------------------------------------------------
  // Types
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       eom;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  // ---------------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tuser   = 1'b0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;

  always #1 clk = ~clk;

  sha256_byte_stream_hasher_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] data_byte
    .in_tuser   (in_tuser),    // [0] has_byte
    .in_tlast   (in_tlast),    // end_of_message
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [31:0] digest_word, [34:32] word_index, rest zero
    .out_tlast  (out_tlast)    // last_word
  );

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  byte_item_t   byte_q[$];     // items not yet presented
  digest_word_t digest_q[$];   // predicted digest words, oldest first

  int  queued_items = 0;
  int  mismatches   = 0;
  int  stall_cycles = 0;
  int  in_gap       = 0;
  int  out_gap      = 0;
  bit  in_taken     = 1'b0;    // in_tvalid && in_tready at the last rising edge

  // ---------------------------------------------------------------------------
  // SHA-256 predictor: chaining value, 16-word schedule window, byte count
  // ---------------------------------------------------------------------------
  logic [31:0] hash_state [8];
  logic [31:0] sched_win  [16];
  logic [60:0] msg_len_bytes;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // drop one byte into the window, big-endian within each word
  function automatic void place_byte(input int pos, input logic [7:0] val);
    int w;
    int sh;
    w  = (pos >> 2) & 15;
    sh = (3 - (pos & 3)) * 8;
    sched_win[w][sh +: 8] = val;
  endfunction

  // 64 rounds on the window (expanded in place), folded into hash_state
  function automatic void sha_compress();
    logic [31:0] v [8];
    logic [31:0] x, y, ch, maj, t1, t2, wt;
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      if (t >= 16) begin
        x = sched_win[(t - 2) & 15];
        y = sched_win[(t - 15) & 15];
        sched_win[t & 15] = (ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10))
                          + sched_win[(t - 7) & 15]
                          + (ror32(y, 7) ^ ror32(y, 18) ^ (y >> 3))
                          + sched_win[t & 15];
      end
      wt  = sched_win[t & 15];
      ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
      maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t1  = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) + ch
          + ROUND_K[(63 - t) * 32 +: 32] + wt;
      t2  = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) + maj;
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + v[i];
  endfunction

  function automatic void restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = START_HASH[(7 - i) * 32 +: 32];
    msg_len_bytes = '0;
  endfunction

  // one accepted input transfer; an end of message queues eight digest words
  function automatic void absorb_item(input byte_item_t it);
    int          pos;
    logic [63:0] bit_len;
    digest_word_t dw;
    if (it.has_byte) begin
      pos = int'(msg_len_bytes[5:0]);
      place_byte(pos, it.data_byte);
      msg_len_bytes = msg_len_bytes + 61'd1;
      if (pos == 63) sha_compress();
    end
    if (it.eom) begin
      pos     = int'(msg_len_bytes[5:0]);
      bit_len = {msg_len_bytes, 3'b000};
      place_byte(pos, PAD_BYTE);
      for (int p = pos + 1; p < 64; p++) place_byte(p, 8'h00);
      // no room left for the length: extra block
      if (pos >= 56) begin
        sha_compress();
        for (int i = 0; i < 16; i++) sched_win[i] = '0;
      end
      sched_win[14] = bit_len[63:32];
      sched_win[15] = bit_len[31:0];
      sha_compress();
      for (int i = 0; i < 8; i++) begin
        dw.word = hash_state[i];
        dw.idx  = 3'(i);
        dw.last = (i == 7);
        digest_q.push_back(dw);
      end
      restart_hash();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic void push_item(input logic has_b, input logic [7:0] d, input logic e);
    byte_item_t it;
    it.has_byte  = has_b;
    it.data_byte = d;
    it.eom       = e;
    byte_q.push_back(it);
    queued_items++;
  endfunction

  // random bytes with stray no-byte transfers; the end either rides on the
  // last byte or comes as a transfer of its own
  function automatic void queue_message(input int len);
    bit closed;
    closed = 1'b0;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) push_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
      if (k == len - 1 && $urandom_range(0, 1) == 1) begin
        push_item(1'b1, 8'($urandom_range(0, 255)), 1'b1);
        closed = 1'b1;
      end else begin
        push_item(1'b1, 8'($urandom_range(0, 255)), 1'b0);
      end
    end
    if (!closed) push_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: inputs change on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    byte_item_t nxt;
    bit         calm;
    calm = (byte_q.size() < CALM_ITEMS);
    if (rst_n) begin
      // input side: hold an item until its transfer, otherwise maybe idle
      if (in_tvalid && !in_taken) begin
        // keep presenting the same item
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (byte_q.size() > 0 && !calm && $urandom_range(0, 5) == 0) begin
        in_gap = $urandom_range(0, 6);   // start a burst of idle cycles
        in_tvalid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        nxt = byte_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= nxt.data_byte;
        in_tuser  <= nxt.has_byte;
        in_tlast  <= nxt.eom;
      end else begin
        in_tvalid <= 1'b0;
      end

      // result side: random stall bursts, none near the end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample on the rising edge, predict on input transfers,
  // check output transfers against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    byte_item_t   got_in;
    digest_word_t exp_w;
    bit           out_taken;
    bit           pending;
    if (rst_n) begin
      in_taken  = in_tvalid && in_tready;
      out_taken = out_tvalid && out_tready;
      if (in_taken) begin
        got_in.has_byte  = in_tuser;
        got_in.data_byte = in_tdata;
        got_in.eom       = in_tlast;
        absorb_item(got_in);
      end
      if (out_taken) begin
        if (digest_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected digest transfer: word %h idx %0d last %b",
                     out_tdata[31:0], out_tdata[34:32], out_tlast);
        end else begin
          exp_w = digest_q.pop_front();
          if (out_tdata[31:0] !== exp_w.word || out_tdata[34:32] !== exp_w.idx ||
              out_tlast !== exp_w.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("digest mismatch: exp word %h idx %0d last %b, got %h idx %0d last %b",
                       exp_w.word, exp_w.idx, exp_w.last,
                       out_tdata[31:0], out_tdata[34:32], out_tlast);
          end
        end
      end

      // watchdog on cycles without any transfer while work is outstanding
      pending = (byte_q.size() != 0) || in_tvalid || (digest_q.size() != 0);
      if (!pending || in_taken || out_taken) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int long_lens [4];
    int nlong;
    int j;
    int tmp;
    int rand_start;

    restart_hash();
    for (int i = 0; i < 16; i++) sched_win[i] = '0;

    // directed part
    push_item(1'b0, 8'ha5, 1'b1);                // empty message
    push_item(1'b1, 8'hff, 1'b1);                // byte and end together
    push_item(1'b1, 8'h00, 1'b0);                // end without a byte,
    push_item(1'b0, 8'hff, 1'b0);                // with an ignored data byte between
    push_item(1'b0, 8'h5a, 1'b1);
    push_item(1'b1, 8'h61, 1'b0);                // "abc"
    push_item(1'b1, 8'h62, 1'b0);
    push_item(1'b1, 8'h63, 1'b1);
    push_item(1'b1, 8'h80, 1'b0);
    push_item(1'b0, 8'h00, 1'b0);                // ignored
    push_item(1'b1, 8'h7f, 1'b0);
    push_item(1'b0, 8'h01, 1'b1);

    // random part: short messages interleaved with lengths around the padding
    // boundaries (room for the length field, full block) in shuffled order
    long_lens = '{55, 56, 63, 64};
    for (int i = 3; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = long_lens[i]; long_lens[i] = long_lens[j]; long_lens[j] = tmp;
    end
    nlong = 0;
    rand_start = queued_items;
    for (int m = 0; (queued_items - rand_start) < RAND_ITEMS || nlong < 4; m++) begin
      if (m % 2 == 1 && nlong < 4) begin
        queue_message(long_lens[nlong]);
        nlong++;
      end else begin
        queue_message($urandom_range(0, 15));
      end
    end

    // reset, released on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for all items to go in and all digest words to come out
    while (byte_q.size() != 0 || in_tvalid || digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/shabsh_pkg.sv
hw/rtl/shabsh_round.sv
hw/rtl/shabsh_sched.sv
hw/rtl/sha256_byte_stream_hasher_top.sv
hw/rtl/shabsh_chk.sv
test/tb_top.sv
